>>> rtl/core/bbfe_pkg.sv
// Shared types for the byte budget FIFO evictor: controller states, result kinds
// and the command/status bundles between controller and datapath.
// No dependencies.
package bbfe_pkg;

	typedef enum logic [1:0] {
		KIND_EVICT      = 2'd0,
		KIND_ACCEPT     = 2'd1,
		KIND_REJ_BUDGET = 2'd2,
		KIND_REJ_FULL   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK_LD,
		ST_WALK_SUB,
		ST_DECIDE,
		ST_EMIT_LD,
		ST_EMIT,
		ST_ACCEPT,
		ST_REJ_BUDGET,
		ST_REJ_FULL
	} state_t;

	typedef struct packed {
		logic  load;       // latch item, total = in use + size, walk from oldest
		logic  walk;       // subtract one stored size, advance walk pointer
		logic  emit_init;  // rewind pointer to oldest for emission
		logic  emit;       // pop oldest entry, advance
		logic  commit;     // write new entry, update total
		logic  out_load;   // load output register
		kind_t out_kind;
	} bbfe_cmd_t;

	typedef struct packed {
		logic over_budget;
		logic walk_stop;
		logic empty;
		logic full_reject;
		logic no_evict;
		logic last_evict;
		logic out_free;
	} bbfe_sts_t;

endpackage

>>> rtl/core/bbfe_ifs.sv
// Handshake channel interfaces: input item, result item and budget write.
// Depends on nothing.
interface bbfe_item_if;
	logic        valid;
	logic        ready;
	logic [31:0] item_bytes;
	logic [15:0] item_tag;
	modport source (output valid, output item_bytes, output item_tag, input ready);
	modport sink (input valid, input item_bytes, input item_tag, output ready);
endinterface

interface bbfe_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [15:0] result_tag;
	logic        last_result;
	modport source (output valid, output result_kind, output result_tag,
		output last_result, input ready);
	modport sink (input valid, input result_kind, input result_tag,
		input last_result, output ready);
endinterface

interface bbfe_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/bbfe_datapath.sv
// Datapath: entry store (size and tag memories), running totals, pointers,
// budget register and result output register. Uses bbfe_pkg.
module bbfe_datapath import bbfe_pkg::*; #(
	parameter int DEPTH     = 64,
	parameter int SIZE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  bbfe_cmd_t   cmd,
	output bbfe_sts_t   sts,
	input  logic [31:0] item_bytes,
	input  logic [15:0] item_tag,
	input  logic        cfg_we,
	input  logic [31:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [15:0] out_tag,
	output logic        out_last
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TOT_W = ((SIZE_BITS > 32) ? SIZE_BITS : 32) + 1;

	logic [SIZE_BITS-1:0] size_mem [DEPTH];
	logic [15:0]          tag_mem  [DEPTH];

	logic [31:0]          budget_q;
	logic [TOT_W-1:0]     bytes_q;
	logic [TOT_W-1:0]     total_q;
	logic [IDX_W-1:0]     oldest_q;
	logic [IDX_W-1:0]     newest_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     evict_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [15:0]          tag_q;
	logic [SIZE_BITS-1:0] rd_size_q;
	logic [15:0]          rd_tag_q;
	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [15:0]          out_tag_q;
	logic                 out_last_q;

	logic [TOT_W-1:0]     budget_ext;
	logic [TOT_W-1:0]     walk_rem;

	function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign budget_ext = TOT_W'(budget_q);
	assign walk_rem   = total_q - TOT_W'(rd_size_q);

	always_comb begin
		sts.over_budget = total_q > budget_ext;
		sts.walk_stop   = (walk_rem < budget_ext) || (evict_q + 1'b1 == count_q);
		sts.empty       = count_q == '0;
		sts.full_reject = ((count_q - evict_q) >= CNT_W'(DEPTH))
			|| (evict_q >= CNT_W'(DEPTH));
		sts.no_evict    = evict_q == '0;
		sts.last_evict  = evict_q == CNT_W'(1);
		sts.out_free    = !out_valid_q || out_ready;
	end

	// Store: one write port, one registered read port following ptr_q.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			size_mem[newest_q] <= size_q;
			tag_mem[newest_q]  <= tag_q;
		end
		rd_size_q <= size_mem[ptr_q];
		rd_tag_q  <= tag_mem[ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q    <= '0;
			bytes_q     <= '0;
			oldest_q    <= '0;
			newest_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				budget_q <= cfg_data;
			if (cmd.emit) begin
				oldest_q <= wrap_next(ptr_q);
				count_q  <= count_q - 1'b1;
			end
			if (cmd.commit) begin
				bytes_q  <= total_q;
				newest_q <= wrap_next(newest_q);
				count_q  <= count_q + 1'b1;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q  <= SIZE_BITS'(item_bytes);
			tag_q   <= item_tag;
			total_q <= bytes_q + TOT_W'(SIZE_BITS'(item_bytes));
			ptr_q   <= oldest_q;
			evict_q <= '0;
		end else if (cmd.walk) begin
			total_q <= walk_rem;
			ptr_q   <= wrap_next(ptr_q);
			evict_q <= evict_q + 1'b1;
		end else if (cmd.emit_init) begin
			ptr_q <= oldest_q;
		end else if (cmd.emit) begin
			ptr_q   <= wrap_next(ptr_q);
			evict_q <= evict_q - 1'b1;
		end
		if (cmd.out_load) begin
			out_kind_q <= cmd.out_kind;
			out_tag_q  <= (cmd.out_kind == KIND_EVICT) ? rd_tag_q : tag_q;
			out_last_q <= cmd.out_kind != KIND_EVICT;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_tag   = out_tag_q;
	assign out_last  = out_last_q;

endmodule

>>> rtl/core/bbfe_ctrl.sv
// Controller state machine: sequences the budget check, the eviction walk,
// the emission of evicted tags and the final result. Uses bbfe_pkg.
module bbfe_ctrl import bbfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bbfe_sts_t sts,
	output bbfe_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.out_kind = KIND_EVICT;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.over_budget && !sts.empty)
					state_d = ST_WALK_LD;
				else
					state_d = ST_DECIDE;
			end
			// Memory read is registered; settle data before subtracting.
			ST_WALK_LD: state_d = ST_WALK_SUB;
			ST_WALK_SUB: begin
				cmd.walk = 1'b1;
				state_d  = sts.walk_stop ? ST_DECIDE : ST_WALK_LD;
			end
			ST_DECIDE: begin
				if (sts.over_budget)
					state_d = ST_REJ_BUDGET;
				else if (sts.full_reject)
					state_d = ST_REJ_FULL;
				else if (sts.no_evict)
					state_d = ST_ACCEPT;
				else begin
					cmd.emit_init = 1'b1;
					state_d       = ST_EMIT_LD;
				end
			end
			ST_EMIT_LD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_EVICT;
					cmd.emit     = 1'b1;
					state_d      = sts.last_evict ? ST_ACCEPT : ST_EMIT_LD;
				end
			end
			ST_ACCEPT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_ACCEPT;
					cmd.commit   = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_REJ_BUDGET: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_REJ_BUDGET;
					state_d      = ST_IDLE;
				end
			end
			ST_REJ_FULL: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_REJ_FULL;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

>>> rtl/core/byte_budget_fifo_evictor_unit.sv
// Byte budget FIFO evictor, top level. Each input item offers an entry (size,
// tag); the unit keeps a FIFO of up to DEPTH entries whose byte total stays within
// the budget register, evicting oldest entries as needed and reporting each evicted
// tag before the accept, or a single reject when the entry cannot fit or the store
// is full. One item is processed at a time. Each stored entry walked by the eviction
// check, and each entry actually evicted (all walked entries or none), passes through
// a load state before its subtract or emit state, because the size and tag store has
// a single registered read port. The budget may be written whenever the unit is idle.
// Depends on bbfe_pkg, bbfe_ifs, bbfe_ctrl and bbfe_datapath.
module byte_budget_fifo_evictor_unit import bbfe_pkg::*; #(
	parameter int DEPTH     = 64,
	parameter int SIZE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	bbfe_cfg_if.sink      cfg,
	bbfe_item_if.sink     items,
	bbfe_result_if.source results
);

	bbfe_cmd_t   cmd;
	bbfe_sts_t   sts;
	logic [1:0]  out_kind;

	assign cfg.ready = 1'b1;

	bbfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bbfe_datapath #(
		.DEPTH     (DEPTH),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.item_bytes (items.item_bytes),
		.item_tag   (items.item_tag),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.data),
		.out_valid  (results.valid),
		.out_ready  (results.ready),
		.out_kind   (out_kind),
		.out_tag    (results.result_tag),
		.out_last   (results.last_result)
	);

	assign results.result_kind = out_kind;

endmodule

>>> dv/bbfe_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the byte budget FIFO evictor: watches the budget, item and result
// channels, keeps its own model of the entry pool and checks every result in order.
// Depends on bbfe_pkg and bbfe_ifs.
module bbfe_checker import bbfe_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	bbfe_cfg_if    cfg,
	bbfe_item_if   items,
	bbfe_result_if results,
	output int     mismatch_count,
	output int     outcomes_pending
);

	typedef struct {
		kind_t       kind;
		logic [15:0] tag;
		logic        last;
	} outcome_t;

	outcome_t outcomes[$];

	logic [31:0] budget_shadow;
	logic [32:0] pool_bytes;
	logic [31:0] pool_sizes[DEPTH];
	logic [15:0] pool_tags[DEPTH];
	int unsigned pool_head;
	int unsigned pool_tail;
	int unsigned pool_count;

	function automatic void note_outcome(input kind_t kind, input logic [15:0] tag,
		input logic last);
		outcome_t o;
		o.kind = kind;
		o.tag  = tag;
		o.last = last;
		outcomes.push_back(o);
	endfunction

	// Work out what one offered entry does to the pool and queue its results.
	function automatic void predict_admission(input logic [31:0] size, input logic [15:0] tag);
		logic [32:0] total;
		int unsigned evicted;
		int unsigned walk;
		total   = pool_bytes + {1'b0, size};
		evicted = 0;
		if (total > {1'b0, budget_shadow}) begin
			walk = pool_head;
			while (evicted < pool_count) begin
				evicted++;
				total -= {1'b0, pool_sizes[walk]};
				walk = (walk + 1) % DEPTH;
				if (total < {1'b0, budget_shadow})
					break;
			end
			if (total > {1'b0, budget_shadow}) begin
				note_outcome(KIND_REJ_BUDGET, tag, 1'b1);
				return;
			end
		end
		if (pool_count - evicted >= DEPTH || evicted >= DEPTH) begin
			note_outcome(KIND_REJ_FULL, tag, 1'b1);
			return;
		end
		repeat (evicted) begin
			note_outcome(KIND_EVICT, pool_tags[pool_head], 1'b0);
			pool_head = (pool_head + 1) % DEPTH;
			pool_count--;
		end
		pool_sizes[pool_tail] = size;
		pool_tags[pool_tail]  = tag;
		pool_tail  = (pool_tail + 1) % DEPTH;
		pool_count++;
		pool_bytes = total;
		note_outcome(KIND_ACCEPT, tag, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		outcome_t want;
		if (!arst_n) begin
			budget_shadow    = '0;
			pool_bytes       = '0;
			pool_head        = 0;
			pool_tail        = 0;
			pool_count       = 0;
			outcomes.delete();
			mismatch_count   = 0;
			outcomes_pending = 0;
		end else begin
			// Results first: anything on the result side belongs to an earlier item.
			if (results.valid && results.ready) begin
				if (outcomes.size() == 0) begin
					$error("unexpected result: result_kind %0d result_tag %h last_result %b",
						results.result_kind, results.result_tag, results.last_result);
					mismatch_count++;
				end else begin
					want = outcomes.pop_front();
					if (results.result_kind !== want.kind) begin
						$error("result_kind: expected %0d, actual %0d",
							want.kind, results.result_kind);
						mismatch_count++;
					end
					if (results.result_tag !== want.tag) begin
						$error("result_tag: expected %h, actual %h",
							want.tag, results.result_tag);
						mismatch_count++;
					end
					if (results.last_result !== want.last) begin
						$error("last_result: expected %b, actual %b",
							want.last, results.last_result);
						mismatch_count++;
					end
				end
			end
			if (cfg.valid && cfg.ready)
				budget_shadow = cfg.data;
			if (items.valid && items.ready)
				predict_admission(items.item_bytes, items.item_tag);
			outcomes_pending = outcomes.size();
		end
	end

endmodule

>>> dv/tb_byte_budget_fifo_evictor_unit.sv
`timescale 1ns / 100ps
// Testbench top for byte_budget_fifo_evictor_unit: drives budget writes and entries,
// stalls the result side at random, and reports the verdict from bbfe_checker.
// Depends on bbfe_pkg, bbfe_ifs, the unit RTL and dv/bbfe_checker.sv.
module tb_byte_budget_fifo_evictor_unit;

	localparam int DEPTH          = 64;
	localparam int SIZE_BITS      = 32;
	localparam int RANDOM_ITEMS   = 160;
	localparam int FILL_ITEMS     = DEPTH + 4;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 4 + 4 * DEPTH;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatch_count;
	int   outcomes_pending;
	bit   stall_on;
	int   holds_asked;
	int   holds_served;
	int   random_sent;

	bbfe_cfg_if    cfg_ch();
	bbfe_item_if   item_ch();
	bbfe_result_if result_ch();

	byte_budget_fifo_evictor_unit #(
		.DEPTH     (DEPTH),
		.SIZE_BITS (SIZE_BITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.items   (item_ch),
		.results (result_ch)
	);

	bbfe_checker #(
		.DEPTH (DEPTH)
	) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_ch),
		.items            (item_ch),
		.results          (result_ch),
		.mismatch_count   (mismatch_count),
		.outcomes_pending (outcomes_pending)
	);

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
	endfunction

	task automatic send_item(input logic [31:0] nbytes, input logic [15:0] tag);
		int gap;
		gap = 0;
		if (stall_on && $urandom_range(0, 99) < 30)
			gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.item_bytes <= nbytes;
		item_ch.item_tag   <= tag;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	// Write the budget once every outstanding result is back.
	task automatic set_budget(input logic [31:0] value);
		item_ch.valid <= 1'b0;
		while (outcomes_pending != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_directed();
		stall_on = 1'b1;
		// budget is still zero from reset
		send_item(32'd0, 16'h0000);
		send_item(32'd1, 16'hFFFF);
		send_item(32'd0, 16'h1234);
		set_budget(32'd100);
		send_item(32'd40, 16'h0101);
		send_item(32'd40, 16'h0202);
		send_item(32'd30, 16'h0303);
		send_item(32'd100, 16'h0404);
		send_item(32'd200, 16'h0505);
		send_item(32'hFFFF_FFFF, 16'hAAAA);
		set_budget(32'd1000);
		send_item(32'd300, 16'h0606);
		send_item(32'd300, 16'h0707);
		// drop the budget below what is held; the next entry walks it back
		set_budget(32'd10);
		send_item(32'd0, 16'h5555);
		set_budget(32'hFFFF_FFFF);
		send_item(32'hFFFF_FFFF, 16'hFFFF);
		send_item(32'hFFFF_FFFF, 16'h0000);
		send_item(32'd1, 16'h00FF);
		// zero budget on a loaded pool: everything goes, remainder lands on the budget
		set_budget(32'd0);
		send_item(32'd0, 16'h7777);
		random_sent += 16;
	endtask

	// Offer more than DEPTH entries to fill the pool, then ask for entries that need most or all of it evicted.
	task automatic run_fill(input bit with_pressure);
		logic [31:0] budget;
		budget = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : $urandom_range(1000, 100000);
		set_budget(budget);
		stall_on = !with_pressure && ($urandom_range(0, 3) != 0);
		if (with_pressure)
			holds_asked++;
		repeat (FILL_ITEMS) send_item($urandom_range(1, 3), 16'($urandom));
		send_item(budget, 16'($urandom));
		send_item(budget - $urandom_range(1, 4), 16'($urandom));
		send_item($urandom_range(0, 3), 16'($urandom));
		random_sent += FILL_ITEMS + 3;
	endtask

	task automatic run_churn();
		logic [31:0] budget;
		logic [31:0] nbytes;
		int          pick;
		budget = $urandom_range(1, 2000);
		set_budget(budget);
		stall_on = ($urandom_range(0, 3) != 0);
		repeat (20) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				nbytes = $urandom_range(0, budget / 4);
			else if (pick < 8)
				nbytes = $urandom_range(budget / 4, budget);
			else if (pick < 9)
				nbytes = $urandom_range(budget, 2 * budget);
			else
				nbytes = $urandom;
			send_item(nbytes, 16'($urandom));
		end
		random_sent += 20;
	endtask

	task automatic run_extreme();
		logic [31:0] budget;
		logic [31:0] nbytes;
		case ($urandom_range(0, 2))
			0: budget = '0;
			1: budget = '1;
			default: budget = $urandom;
		endcase
		set_budget(budget);
		stall_on = ($urandom_range(0, 3) != 0);
		repeat (15) begin
			case ($urandom_range(0, 3))
				0: nbytes = '0;
				1: nbytes = '1;
				2: nbytes = $urandom;
				default: nbytes = $urandom_range(0, 15);
			endcase
			send_item(nbytes, 16'($urandom));
		end
		random_sent += 15;
	endtask

	initial begin : stimulus
		arst_n             = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.data        = '0;
		item_ch.valid      = 1'b0;
		item_ch.item_bytes = '0;
		item_ch.item_tag   = '0;
		stall_on           = 1'b0;
		holds_asked        = 0;
		random_sent        = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		run_fill(1'b1);
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: begin
					if (random_sent + FILL_ITEMS + 3 <= RANDOM_ITEMS)
						run_fill(1'b0);
					else
						run_churn();
				end
				1, 2, 3: run_extreme();
				default: run_churn();
			endcase
		end
		item_ch.valid <= 1'b0;
		while (outcomes_pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && outcomes_pending == 0)
			$display("byte_budget_fifo_evictor_unit verification clean");
		else
			$display("byte_budget_fifo_evictor_unit verification failed");
		$finish;
	end

	initial begin : result_sink
		int gap;
		holds_served    = 0;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (holds_served != holds_asked) begin
				// hold off long enough for the unit to back up into its input
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				holds_served++;
			end else if (stall_on && $urandom_range(0, 99) < 25) begin
				result_ch.ready <= 1'b0;
				gap = pick_gap();
				repeat (gap - 1) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cfg_ch.valid && cfg_ch.ready) || (item_ch.valid && item_ch.ready) ||
				(result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("byte_budget_fifo_evictor_unit verification failed");
		$finish;
	end

endmodule
